// File: hw/rtl/assert_macros.svh
// Assertion macros for the indexed block search RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IBS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define IBS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define IBS_ASSERT(label, clk, rst, prop)
`define IBS_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hw/rtl/ibs_pkg.sv
// Package for the indexed block search core: table sizes, derived widths and codes.
// Used by ibs_div and indexed_block_search_core; depends on nothing.
package ibs_pkg;

   localparam int INDEX_DEPTH  = 32;
   localparam int RECORD_DEPTH = 128;
   localparam int KEY_WIDTH    = 16;

   localparam int IDX_AW = $clog2(INDEX_DEPTH);
   localparam int IC_W   = $clog2(INDEX_DEPTH + 1);
   localparam int REC_AW = $clog2(RECORD_DEPTH);
   localparam int RC_W   = $clog2(RECORD_DEPTH + 1);
   localparam int CSR_DW = (IC_W > RC_W) ? IC_W : RC_W;
   localparam int CSR_AW = 2;
   localparam int CMD_W  = 2;
   localparam int SLOT_W = 7;

   localparam logic [CMD_W-1:0] CMD_WRITE_INDEX  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_RECORD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH       = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_INDEX_COUNT  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_RECORD_COUNT = 2'd1;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

endpackage

// File: hw/rtl/indexed_block_search_core.sv
// Index and record writes give no result and leave busy low.
// A search holds busy through S binary steps (at most log2(index_count) + 1, each through
// the index read port and the key comparator) and B records scanned at one a cycle;
// rsp_valid pulses once at the end.
// A write to either count register runs the divider for block size; busy is high while it runs.
// Synchronous active-high reset: idle, both counts and block size one, tables undefined.
`include "assert_macros.svh"

module indexed_block_search_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ibs_pkg::CMD_W-1:0]        req_cmd,
   input  logic [ibs_pkg::SLOT_W-1:0]       req_slot,
   input  logic signed [ibs_pkg::KEY_WIDTH-1:0] req_key,
   input  logic [ibs_pkg::REC_AW-1:0]       req_start_req,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [ibs_pkg::REC_AW-1:0]       rsp_position,
   output logic [ibs_pkg::IC_W-1:0]         rsp_block,
   input  logic                             csr_we,
   input  logic [ibs_pkg::CSR_AW-1:0]       csr_index,
   input  logic [ibs_pkg::CSR_DW-1:0]       csr_wdata
);

   localparam int SUM_W = ibs_pkg::RC_W + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BS     = 3'd1;
   localparam logic [2:0] ST_BS_CMP = 3'd2;
   localparam logic [2:0] ST_STRT   = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;

   // Tables and their registered read data.
   ibs_pkg::key_type               max_key_mem_ff [ibs_pkg::INDEX_DEPTH];
   logic [ibs_pkg::REC_AW-1:0]     start_mem_ff   [ibs_pkg::INDEX_DEPTH];
   ibs_pkg::key_type               rec_key_mem_ff [ibs_pkg::RECORD_DEPTH];
   ibs_pkg::key_type               idx_key_rd_ff;
   logic [ibs_pkg::REC_AW-1:0]     idx_start_rd_ff;
   ibs_pkg::key_type               rec_rd_ff;

   logic [2:0]                     state_ff, state_in;
   logic [ibs_pkg::IC_W-1:0]       index_count_ff, index_count_in;
   logic [ibs_pkg::RC_W-1:0]       record_count_ff, record_count_in;
   ibs_pkg::key_type               key_ff, key_in;
   logic [ibs_pkg::IC_W-1:0]       low_ff, low_in;
   logic [ibs_pkg::IC_W-1:0]       hi1_ff, hi1_in;
   logic [ibs_pkg::IC_W-1:0]       mid_ff, mid_in;
   logic [ibs_pkg::RC_W-1:0]       scan_addr_ff, scan_addr_in;
   logic [ibs_pkg::RC_W-1:0]       stop_ff, stop_in;
   logic                           pend_vld_ff, pend_vld_in;
   logic [ibs_pkg::REC_AW-1:0]     pend_pos_ff, pend_pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [ibs_pkg::REC_AW-1:0]     rsp_position_ff, rsp_position_in;
   logic [ibs_pkg::IC_W-1:0]       rsp_block_ff, rsp_block_in;

   logic                           accept;
   logic                           idx_we, rec_we;
   logic [ibs_pkg::IDX_AW-1:0]     idx_raddr;
   logic [ibs_pkg::REC_AW-1:0]     rec_raddr;
   logic                           bs_open;
   logic [ibs_pkg::IC_W:0]         mid_sum;
   logic [ibs_pkg::IC_W-1:0]       mid;
   logic [SUM_W-1:0]               stop_sum;
   logic                           issuing;
   logic                           div_go, div_busy;
   logic [ibs_pkg::RC_W-1:0]       block_size;
   logic [ibs_pkg::IC_W-1:0]       idx_sat;
   logic [ibs_pkg::RC_W-1:0]       rec_sat;
   logic [ibs_pkg::IC_W-1:0]       div_divisor;
   logic [ibs_pkg::RC_W-1:0]       div_dividend;

   assign busy   = (state_ff != ST_IDLE) | div_busy;
   assign accept = start & ~busy;
   assign idx_we = accept && (req_cmd == ibs_pkg::CMD_WRITE_INDEX)
                   && ({1'b0, req_slot} < (ibs_pkg::SLOT_W + 1)'(ibs_pkg::INDEX_DEPTH));
   assign rec_we = accept && (req_cmd == ibs_pkg::CMD_WRITE_RECORD)
                   && ({1'b0, req_slot} < (ibs_pkg::SLOT_W + 1)'(ibs_pkg::RECORD_DEPTH));

   // Register values are clamped into their legal ranges as they are written.
   always_comb begin
      idx_sat = csr_wdata[ibs_pkg::IC_W-1:0];
      if (idx_sat == '0) begin
         idx_sat = ibs_pkg::IC_W'(1);
      end else if (idx_sat > ibs_pkg::IC_W'(ibs_pkg::INDEX_DEPTH)) begin
         idx_sat = ibs_pkg::IC_W'(ibs_pkg::INDEX_DEPTH);
      end
      rec_sat = csr_wdata[ibs_pkg::RC_W-1:0];
      if (rec_sat == '0) begin
         rec_sat = ibs_pkg::RC_W'(1);
      end else if (rec_sat > ibs_pkg::RC_W'(ibs_pkg::RECORD_DEPTH)) begin
         rec_sat = ibs_pkg::RC_W'(ibs_pkg::RECORD_DEPTH);
      end
   end

   always_comb begin
      index_count_in  = index_count_ff;
      record_count_in = record_count_ff;
      div_go          = 1'b0;
      if (csr_we) begin
         case (csr_index)
            ibs_pkg::CSR_INDEX_COUNT: begin
               index_count_in = idx_sat;
               div_go         = 1'b1;
            end
            ibs_pkg::CSR_RECORD_COUNT: begin
               record_count_in = rec_sat;
               div_go          = 1'b1;
            end
            default: begin
               div_go = 1'b0;
            end
         endcase
      end
   end

   assign div_dividend = record_count_in;
   assign div_divisor  = index_count_in;

   ibs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (block_size)
   );

   // Binary search bounds: low and one past high, the open range is low < hi1.
   assign bs_open   = (low_ff < hi1_ff);
   assign mid_sum   = {1'b0, low_ff} + {1'b0, hi1_ff} - 1'b1;
   assign mid       = mid_sum[ibs_pkg::IC_W:1];
   assign idx_raddr = bs_open ? mid[ibs_pkg::IDX_AW-1:0] : low_ff[ibs_pkg::IDX_AW-1:0];
   assign stop_sum  = SUM_W'(idx_start_rd_ff) + SUM_W'(block_size);
   assign issuing   = (scan_addr_ff < stop_ff);
   assign rec_raddr = scan_addr_ff[ibs_pkg::REC_AW-1:0];

   always_comb begin
      state_in        = state_ff;
      key_in          = key_ff;
      low_in          = low_ff;
      hi1_in          = hi1_ff;
      mid_in          = mid_ff;
      scan_addr_in    = scan_addr_ff;
      stop_in         = stop_ff;
      pend_vld_in     = 1'b0;
      pend_pos_in     = pend_pos_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_block_in    = rsp_block_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == ibs_pkg::CMD_SEARCH)) begin
               key_in   = req_key;
               low_in   = '0;
               hi1_in   = index_count_ff;
               state_in = ST_BS;
            end
         end
         ST_BS: begin
            if (bs_open) begin
               mid_in   = mid;
               state_in = ST_BS_CMP;
            end else if (low_ff < index_count_ff) begin
               state_in = ST_STRT;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               rsp_block_in    = low_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_BS_CMP: begin
            if (idx_key_rd_ff >= key_ff) begin
               hi1_in = mid_ff;
            end else begin
               low_in = mid_ff + 1'b1;
            end
            state_in = ST_BS;
         end
         ST_STRT: begin
            scan_addr_in = ibs_pkg::RC_W'(idx_start_rd_ff);
            if (stop_sum > SUM_W'(ibs_pkg::RECORD_DEPTH)) begin
               stop_in = ibs_pkg::RC_W'(ibs_pkg::RECORD_DEPTH);
            end else begin
               stop_in = stop_sum[ibs_pkg::RC_W-1:0];
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // One record is read each cycle and compared the cycle after.
            if (pend_vld_ff && (rec_rd_ff == key_ff)) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = pend_pos_ff;
               rsp_block_in    = low_ff;
               state_in        = ST_IDLE;
            end else if (issuing) begin
               pend_vld_in  = 1'b1;
               pend_pos_in  = scan_addr_ff[ibs_pkg::REC_AW-1:0];
               scan_addr_in = scan_addr_ff + 1'b1;
            end else if (!pend_vld_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               rsp_block_in    = low_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (idx_we) begin
         max_key_mem_ff[req_slot[ibs_pkg::IDX_AW-1:0]] <= req_key;
         start_mem_ff[req_slot[ibs_pkg::IDX_AW-1:0]]   <= req_start_req;
      end
      idx_key_rd_ff   <= max_key_mem_ff[idx_raddr];
      idx_start_rd_ff <= start_mem_ff[idx_raddr];
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_key_mem_ff[req_slot[ibs_pkg::REC_AW-1:0]] <= req_key;
      end
      rec_rd_ff <= rec_key_mem_ff[rec_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         index_count_ff  <= ibs_pkg::IC_W'(1);
         record_count_ff <= ibs_pkg::RC_W'(1);
         pend_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         index_count_ff  <= index_count_in;
         record_count_ff <= record_count_in;
         pend_vld_ff     <= pend_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      key_ff          <= key_in;
      low_ff          <= low_in;
      hi1_ff          <= hi1_in;
      mid_ff          <= mid_in;
      scan_addr_ff    <= scan_addr_in;
      stop_ff         <= stop_in;
      pend_pos_ff     <= pend_pos_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_block_ff    <= rsp_block_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_block    = rsp_block_ff;

   `IBS_ASSERT(a_search_goes_busy, clock, reset, accept && (req_cmd == ibs_pkg::CMD_SEARCH) |=> busy)
   `IBS_ASSERT(a_strobe_one_cycle, clock, reset, rsp_valid |=> !rsp_valid)
   `IBS_ASSERT(a_miss_position_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_position == '0)
   `IBS_ASSERT(a_bs_bounds, clock, reset, (state_ff == ST_BS) || (state_ff == ST_BS_CMP) |-> (low_ff <= hi1_ff) && (hi1_ff <= index_count_ff))
   `IBS_ASSERT_NEVER(a_scan_past_stop, clock, reset, (state_ff == ST_SCAN) && (scan_addr_ff > stop_ff))

endmodule

// File: hw/rtl/ibs_div.sv
// Restoring divider that works out the block size, one quotient bit per cycle.
// Depends on ibs_pkg for the count widths.
module ibs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [ibs_pkg::RC_W-1:0]     dividend,
   input  logic [ibs_pkg::IC_W-1:0]     divisor,
   output logic                         busy,
   output logic [ibs_pkg::RC_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(ibs_pkg::RC_W + 1);

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [ibs_pkg::IC_W:0]     rem_ff, rem_in;
   logic [ibs_pkg::RC_W-1:0]   dq_ff, dq_in;
   logic [ibs_pkg::IC_W-1:0]   divisor_ff, divisor_in;
   logic [ibs_pkg::RC_W-1:0]   quotient_ff, quotient_in;
   logic [ibs_pkg::IC_W:0]     shifted;
   logic                       qbit;

   always_comb begin
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      dq_in       = dq_ff;
      divisor_in  = divisor_ff;
      quotient_in = quotient_ff;
      shifted     = {rem_ff[ibs_pkg::IC_W-1:0], dq_ff[ibs_pkg::RC_W-1]};
      qbit        = (shifted >= {1'b0, divisor_ff});
      if (go) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(ibs_pkg::RC_W);
         rem_in     = '0;
         dq_in      = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? (shifted - {1'b0, divisor_ff}) : shifted;
         dq_in  = {dq_ff[ibs_pkg::RC_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in     = 1'b0;
            quotient_in = {dq_ff[ibs_pkg::RC_W-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         quotient_ff <= ibs_pkg::RC_W'(1);
      end else begin
         busy_ff     <= busy_in;
         quotient_ff <= quotient_in;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quotient_ff;

endmodule

// File: dv/indexed_block_search_core_test.sv
// Self-checking testbench for indexed_block_search_core: index and record writes, searches,
// register writes with saturation, random idling on the request side and result checking.
// Depends on ibs_pkg and the core RTL only.
module indexed_block_search_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ibs_pkg::*;

   // Command and register codes that the package leaves unnamed.
   localparam logic [CMD_W-1:0]  CMD_RESERVED = 2'd3;
   localparam logic [CSR_AW-1:0] CSR_SPARE_2  = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_SPARE_3  = 2'd3;

   // Longest search: every binary step plus a full scan of the store, with some margin.
   localparam int SEARCH_CYCLES = 2 * (IDX_AW + 1) + RECORD_DEPTH + 8;

   typedef struct packed {
      logic              found;
      logic [REC_AW-1:0] position;
      logic [IC_W-1:0]   block;
   } lookup_result_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0]  req_cmd = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   key_type           req_key = '0;
   logic [REC_AW-1:0] req_start_req = '0;
   logic              rsp_valid;
   logic              rsp_found;
   logic [REC_AW-1:0] rsp_position;
   logic [IC_W-1:0]   rsp_block;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   indexed_block_search_core u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_slot      (req_slot),
      .req_key       (req_key),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_block     (rsp_block),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Shadow copy of the tables and registers.
   key_type           idx_max [INDEX_DEPTH];
   logic [REC_AW-1:0] idx_first [INDEX_DEPTH];
   key_type           rec_key [RECORD_DEPTH];
   int                blk_count = 1;
   int                rec_count = 1;
   int                blk_len = 1;

   lookup_result_type expected_lookups [$];

   int  errors = 0;
   int  n_lookups = 0;
   int  n_hits = 0;
   int  n_beyond = 0;
   int  n_table_writes = 0;
   int  n_ignored = 0;
   int  n_csr_writes = 0;
   bit  no_gaps = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("indexed_block_search_core_test: errors");
      $finish;
   end

   task automatic flag_error(input string what);
      errors++;
      if (errors <= 10) $display("%0t ns: %s", $time, what);
   endtask

   function automatic void apply_csr(input logic [CSR_AW-1:0] idx,
                                     input logic [CSR_DW-1:0] val);
      int v;
      if (idx == CSR_INDEX_COUNT) begin
         v = int'(val[IC_W-1:0]);
         blk_count = (v < 1) ? 1 : (v > INDEX_DEPTH) ? INDEX_DEPTH : v;
      end else if (idx == CSR_RECORD_COUNT) begin
         v = int'(val[RC_W-1:0]);
         rec_count = (v < 1) ? 1 : (v > RECORD_DEPTH) ? RECORD_DEPTH : v;
      end else begin
         return;
      end
      blk_len = rec_count / blk_count;
   endfunction

   // Updates the shadow tables for one accepted word and queues the search answer.
   function automatic void predict_lookup(input logic [CMD_W-1:0] cmd,
                                          input logic [SLOT_W-1:0] slot,
                                          input key_type key,
                                          input logic [REC_AW-1:0] first_rec);
      int lo, hi, mid, first, stop, i;
      lookup_result_type r;
      if (cmd == CMD_WRITE_INDEX) begin
         if (slot < INDEX_DEPTH) begin
            idx_max[slot] = key;
            idx_first[slot] = first_rec;
            n_table_writes++;
         end else begin
            n_ignored++;
         end
      end else if (cmd == CMD_WRITE_RECORD) begin
         if (slot < RECORD_DEPTH) begin
            rec_key[slot] = key;
            n_table_writes++;
         end else begin
            n_ignored++;
         end
      end else if (cmd == CMD_SEARCH) begin
         lo = 0;
         hi = blk_count - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (idx_max[mid] >= key) hi = mid - 1;
            else lo = mid + 1;
         end
         r.found = 1'b0;
         r.position = '0;
         r.block = lo[IC_W-1:0];
         if (lo < blk_count) begin
            first = int'(idx_first[lo]);
            stop = first + blk_len;
            if (stop > RECORD_DEPTH) stop = RECORD_DEPTH;
            for (i = first; i < stop && !r.found; i++) begin
               if (rec_key[i] == key) begin
                  r.found = 1'b1;
                  r.position = i[REC_AW-1:0];
               end
            end
         end else begin
            n_beyond++;
         end
         if (r.found) n_hits++;
         n_lookups++;
         expected_lookups.push_back(r);
      end else begin
         n_ignored++;
      end
   endfunction

   // Sends one word, after a random gap unless no_gaps is set, and predicts it once it is accepted.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                            input key_type key, input logic [REC_AW-1:0] first_rec);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_slot <= slot;
      req_key <= key;
      req_start_req <= first_rec;
      do @(posedge clock); while (busy !== 1'b0);
      predict_lookup(cmd, slot, key, first_rec);
   endtask

   // Always waits on the clock before it checks the queue, so the next word is driven in a later step.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_lookups.size() != 0);
   endtask

   // Registers change only with the core idle; the task first waits out every answer and the longest search.
   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      wait_drained();
      repeat (SEARCH_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_csr(idx, val);
      n_csr_writes++;
      repeat (2) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   function automatic key_type key_above_maxima();
      int top, b;
      top = -32768;
      for (b = 0; b < blk_count; b++)
         if (int'(idx_max[b]) > top) top = int'(idx_max[b]);
      if (top >= 32767) return key_type'($urandom);
      return key_type'(top + int'($urandom_range(1, 32767 - top)));
   endfunction

   // Sorted maxima over consecutive blocks of records, keys ascending through the store.
   task automatic load_sorted_tables();
      int b, j, k, last, peak, first;
      k = -32768 + int'($urandom_range(0, 8000));
      for (b = 0; b < blk_count; b++) begin
         last = k;
         for (j = 0; j < blk_len; j++) begin
            send_word(CMD_WRITE_RECORD, SLOT_W'(b * blk_len + j), key_type'(k),
                      REC_AW'($urandom));
            last = k;
            k += int'($urandom_range(0, 300));
         end
         peak = last + (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 50)) : 0);
         first = (blk_len > 0) ? b * blk_len : int'($urandom_range(0, RECORD_DEPTH - 1));
         send_word(CMD_WRITE_INDEX, SLOT_W'(b), key_type'(peak), REC_AW'(first));
         k = peak + int'($urandom_range(1, 300));
      end
   endtask

   // Every entry is written once so that no later search reads an unwritten one.
   task automatic test_table_fill();
      int i;
      for (i = 0; i < RECORD_DEPTH; i++)
         send_word(CMD_WRITE_RECORD, SLOT_W'(i), key_type'($urandom), REC_AW'($urandom));
      for (i = 0; i < INDEX_DEPTH; i++)
         send_word(CMD_WRITE_INDEX, SLOT_W'(i), key_type'($urandom), REC_AW'($urandom));
   endtask

   task automatic test_directed_cases();
      write_csr(CSR_INDEX_COUNT, 8'd4);
      write_csr(CSR_RECORD_COUNT, 8'd16);
      send_word(CMD_WRITE_INDEX, 7'd0, key_type'(-100), 7'd0);
      send_word(CMD_WRITE_INDEX, 7'd1, key_type'(0), 7'd4);
      send_word(CMD_WRITE_INDEX, 7'd2, key_type'(1000), 7'd8);
      // The last block starts near the end, so its scan is cut at the end of the store.
      send_word(CMD_WRITE_INDEX, 7'd3, key_type'(32767), 7'd126);
      send_word(CMD_WRITE_RECORD, 7'd0, key_type'(-32768), 7'd127);
      send_word(CMD_WRITE_RECORD, 7'd3, key_type'(-100), 7'd0);
      send_word(CMD_WRITE_RECORD, 7'd5, key_type'(0), 7'd0);
      send_word(CMD_WRITE_RECORD, 7'd126, key_type'(500), 7'd0);
      send_word(CMD_WRITE_RECORD, 7'd127, key_type'(32767), 7'd0);
      send_word(CMD_WRITE_INDEX, 7'd127, key_type'(5), 7'd0);
      send_word(CMD_RESERVED, 7'd127, key_type'(-1), 7'd127);
      send_word(CMD_SEARCH, 7'd0, key_type'(-32768), 7'd0);
      send_word(CMD_SEARCH, 7'd0, key_type'(-100), 7'd0);
      send_word(CMD_SEARCH, 7'd0, key_type'(0), 7'd0);
      send_word(CMD_SEARCH, 7'd0, key_type'(999), 7'd0);
      send_word(CMD_SEARCH, 7'd0, key_type'(500), 7'd0);
      send_word(CMD_SEARCH, 7'd127, key_type'(32767), 7'd127);
      // Lowering the top maximum leaves the largest key above every block.
      send_word(CMD_WRITE_INDEX, 7'd3, key_type'(30000), 7'd126);
      send_word(CMD_SEARCH, 7'd0, key_type'(32767), 7'd0);
      // Block one now has a larger maximum than block two.
      send_word(CMD_WRITE_INDEX, 7'd1, key_type'(5000), 7'd4);
      send_word(CMD_SEARCH, 7'd0, key_type'(2000), 7'd0);
   endtask

   task automatic test_register_limits();
      logic [CSR_AW-1:0] idx [8];
      logic [CSR_DW-1:0] val [8];
      int i;
      idx = '{CSR_INDEX_COUNT, CSR_INDEX_COUNT, CSR_INDEX_COUNT, CSR_RECORD_COUNT,
              CSR_RECORD_COUNT, CSR_RECORD_COUNT, CSR_SPARE_2, CSR_SPARE_3};
      val = '{8'd0, 8'hFF, 8'd33, 8'd0, 8'hFF, 8'd200, 8'hAA, 8'h55};
      for (i = 0; i < 8; i++) begin
         write_csr(idx[i], val[i]);
         send_word(CMD_SEARCH, SLOT_W'($urandom), key_type'(32767), REC_AW'($urandom));
         send_word(CMD_SEARCH, SLOT_W'($urandom), rec_key[$urandom_range(0, RECORD_DEPTH - 1)],
                   REC_AW'($urandom));
      end
   endtask

   task automatic test_search_phase(input int ic_raw, input int rc_raw, input int count);
      int done, pick, span;
      key_type probe;
      write_csr(CSR_INDEX_COUNT, CSR_DW'(ic_raw));
      write_csr(CSR_RECORD_COUNT, CSR_DW'(rc_raw));
      load_sorted_tables();
      span = blk_count * blk_len;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 39) == 0) no_gaps = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            if (pick < 50 && span > 0) probe = rec_key[$urandom_range(0, span - 1)];
            else if (pick < 62) probe = idx_max[$urandom_range(0, blk_count - 1)];
            else if (pick < 70) probe = key_above_maxima();
            else probe = key_type'($urandom);
            // Now and then the sender holds off until every answer is back.
            if (pick >= 78) wait_drained();
            send_word(CMD_SEARCH, SLOT_W'($urandom), probe, REC_AW'($urandom));
            done++;
         end else if (pick < 89) begin
            send_word(CMD_WRITE_RECORD, SLOT_W'($urandom), key_type'($urandom),
                      REC_AW'($urandom));
         end else if (pick < 96) begin
            send_word(CMD_WRITE_INDEX, SLOT_W'($urandom), key_type'($urandom),
                      REC_AW'($urandom));
         end else begin
            send_word(CMD_RESERVED, SLOT_W'($urandom), key_type'($urandom), REC_AW'($urandom));
         end
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_random_phases();
      int p, ic, rc;
      test_search_phase(32, 128, 40);
      test_search_phase(1, 128, 15);
      test_search_phase(32, 32, 30);
      test_search_phase(7, 3, 20);
      test_search_phase(0, 0, 10);
      for (p = 0; p < 4; p++) begin
         ic = $urandom_range(1, INDEX_DEPTH);
         rc = ic * int'($urandom_range(1, 4)) + int'($urandom_range(0, ic - 1));
         if (rc > RECORD_DEPTH) rc = RECORD_DEPTH;
         test_search_phase(ic, rc, 35);
      end
   endtask

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_lookups.size() == 0) begin
            flag_error($sformatf("result with nothing expected: found %b position %0d block %0d",
                                 rsp_found, rsp_position, rsp_block));
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_found !== want.found)
               flag_error($sformatf("found: expected %b, got %b", want.found, rsp_found));
            if (rsp_position !== want.position)
               flag_error($sformatf("position: expected %0d, got %0d",
                                    want.position, rsp_position));
            if (rsp_block !== want.block)
               flag_error($sformatf("block: expected %0d, got %0d", want.block, rsp_block));
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill();
      test_directed_cases();
      test_register_limits();
      test_random_phases();
      wait_drained();
      repeat (SEARCH_CYCLES) @(posedge clock);
      if (expected_lookups.size() != 0)
         flag_error($sformatf("%0d searches never answered", expected_lookups.size()));
      $display("Covered %0d searches (%0d hits, %0d above every block maximum), %0d table writes,",
               n_lookups, n_hits, n_beyond, n_table_writes);
      $display("%0d ignored words and %0d register writes; %0d mismatches.",
               n_ignored, n_csr_writes, errors);
      if (errors == 0) begin
         $display("indexed_block_search_core_test: clean");
      end else begin
         $display("indexed_block_search_core_test: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ibs_pkg.sv
hw/rtl/ibs_div.sv
hw/rtl/indexed_block_search_core.sv
dv/indexed_block_search_core_test.sv
